FILE: rtl/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;
	typedef enum logic [1:0] {
		OP_READY = 2'd0,
		OP_SCHED = 2'd1,
		OP_SLEEP = 2'd2,
		OP_WAKE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_READY = 2'd1,
		ST_SLEEP = 2'd2
	} pstate_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_DECODE,
		C_DISPATCH,
		C_SCAN,
		C_INSERT,
		C_POP,
		C_DONE
	} cstate_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan_start;
		logic scan_step;
		logic ins_start;
		logic ins_step;
		logic pop;
		logic pop_step;
		logic finish;
	} prq_cmd_t;

	typedef struct packed {
		logic need_insert;
		logic need_pop;
		logic is_wake;
		logic scan_hit;
		logic scan_last;
		logic ins_done;
		logic pop_done;
	} prq_stat_t;
endpackage
`default_nettype wire

FILE: rtl/prq_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface prq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  proc_id;
	logic [7:0]  prio;
	logic [15:0] wait_event;
	modport source (output valid, opcode, proc_id, prio, wait_event, input ready);
	modport sink (input valid, opcode, proc_id, prio, wait_event, output ready);
endinterface

interface prq_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] run_id;
	logic       run_valid;
	logic [4:0] ready_count;
	logic [3:0] woken_count;
	logic       status;
	modport source (output valid, run_id, run_valid, ready_count, woken_count, status,
		input ready);
	modport sink (input valid, run_id, run_valid, ready_count, woken_count, status,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: decode and dispatch after acceptance, then a queue insertion walk back from
// the tail and/or the removal shift of a schedule, then the result
// wakeup: decode, then a scan of entries 1 to NUM_PROCS-1, each hit adding one insertion walk
// throughput: one transaction at a time, next accepted the cycle after the result
// reset: arst_n asynchronous; all entries free, queue empty, entry 0 running
module priority_ready_queue_scheduler #(
	parameter int NUM_PROCS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	prq_in_if.sink   req,
	prq_out_if.source rsp
);
	import prq_pkg::*;
	prq_cmd_t  cmd;
	prq_stat_t st;
	logic busy, done;

	// accept only when idle; result held until taken
	assign req.ready = !busy;
	assign rsp.valid = done;

	prq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(req.valid && req.ready),
		.out_fire(rsp.valid && rsp.ready),
		.st(st), .cmd(cmd), .busy(busy), .done(done)
	);

	prq_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_opcode(req.opcode), .in_proc_id(req.proc_id),
		.in_prio(req.prio), .in_wait_event(req.wait_event),
		.st(st),
		.run_id(rsp.run_id), .run_valid(rsp.run_valid),
		.ready_count(rsp.ready_count), .woken_count(rsp.woken_count),
		.status(rsp.status)
	);
endmodule
`default_nettype wire

FILE: rtl/prq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module prq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            out_fire,
	input  wire prq_pkg::prq_stat_t st,
	output prq_pkg::prq_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);
	import prq_pkg::*;
	cstate_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: if (in_fire) state_d = C_DECODE;
			C_DECODE: begin
				if (st.is_wake) state_d = C_SCAN;
				else state_d = C_DISPATCH;
			end
			C_DISPATCH: begin
				if (st.need_insert) state_d = C_INSERT;
				else if (st.need_pop) state_d = C_POP;
				else state_d = C_DONE;
			end
			C_SCAN: begin
				if (st.scan_hit) state_d = C_INSERT;
				else if (st.scan_last) state_d = C_DONE;
			end
			C_INSERT: begin
				if (st.ins_done) begin
					if (st.is_wake) state_d = st.scan_last ? C_DONE : C_SCAN;
					else if (st.need_pop) state_d = C_POP;
					else state_d = C_DONE;
				end
			end
			C_POP: if (st.pop_done) state_d = C_DONE;
			C_DONE: if (out_fire) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != C_IDLE);
		done = (state_q == C_DONE);
		case (state_q)
			C_IDLE: cmd.load = in_fire;
			C_DECODE: begin
				cmd.decode = 1'b1;
				cmd.scan_start = st.is_wake;
			end
			C_DISPATCH: begin
				cmd.ins_start = st.need_insert;
				cmd.pop = !st.need_insert && st.need_pop;
			end
			C_SCAN: begin
				cmd.scan_step = !st.scan_hit;
				cmd.ins_start = st.scan_hit;
			end
			C_INSERT: begin
				cmd.ins_step = 1'b1;
				cmd.scan_step = st.ins_done && st.is_wake;
			end
			C_POP: cmd.pop_step = 1'b1;
			C_DONE: cmd.finish = out_fire;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/prq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module prq_dp #(
	parameter int NUM_PROCS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prq_pkg::prq_cmd_t cmd,
	input  wire logic [1:0]        in_opcode,
	input  wire logic [3:0]        in_proc_id,
	input  wire logic [7:0]        in_prio,
	input  wire logic [15:0]       in_wait_event,
	output prq_pkg::prq_stat_t     st,
	output logic [3:0]             run_id,
	output logic                   run_valid,
	output logic [4:0]             ready_count,
	output logic [3:0]             woken_count,
	output logic                   status
);
	import prq_pkg::*;
	localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int LW = $clog2(NUM_PROCS + 1);

	// per-entry tables (state, priority, wait event) and the ready-queue order
	pstate_t        est_q [NUM_PROCS];
	logic [7:0]     epr_q [NUM_PROCS];
	logic [15:0]    eev_q [NUM_PROCS];
	logic [IW-1:0]  ord_q [NUM_PROCS];
	logic [LW-1:0]  len_q;
	logic [IW-1:0]  cur_q;
	logic           curv_q;

	logic [1:0]     op_q;
	logic [3:0]     pid_q;
	logic [7:0]     pr_q;
	logic [15:0]    ev_q;
	logic           rej_q, need_ins_q, need_pop_q;
	logic [3:0]     woken_q;
	logic [IW-1:0]  scan_q;
	logic [IW-1:0]  ins_id_q;
	logic [7:0]     ins_pr_q;
	logic [LW-1:0]  ptr_q;
	logic           ins_found_q;

	logic           pid_ok;
	logic [IW-1:0]  pid_ix;
	logic           is_cur;
	logic           scan_hit;
	logic [IW-1:0]  ord_m1;

	assign pid_ok = ({28'd0, pid_q} < NUM_PROCS);
	assign pid_ix = IW'({28'd0, pid_q});
	assign is_cur = curv_q && ({28'd0, pid_q} == {{(32-IW){1'b0}}, cur_q});
	assign scan_hit = (est_q[scan_q] == ST_SLEEP) && (eev_q[scan_q] == ev_q);
	assign ord_m1 = ord_q[IW'(ptr_q - LW'(1))];

	assign st.is_wake = (op_q == OP_WAKE);
	assign st.need_insert = need_ins_q;
	assign st.need_pop = need_pop_q;
	assign st.scan_hit = scan_hit;
	assign st.scan_last = ({{(32-IW){1'b0}}, scan_q} == NUM_PROCS - 1);
	// insertion walks back from the tail, shifting lower-priority entries up
	assign st.ins_done = (ptr_q == '0) || (epr_q[ord_m1] >= ins_pr_q) || ins_found_q;
	assign st.pop_done = ({{(32-LW){1'b0}}, ptr_q} + 1 >= {{(32-LW){1'b0}}, len_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROCS; i++) begin
				est_q[i] <= ST_FREE;
				epr_q[i] <= '0;
				eev_q[i] <= '0;
			end
			len_q <= '0;
			cur_q <= '0;
			curv_q <= 1'b1;
			ins_found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= in_opcode;
				pid_q <= in_proc_id;
				pr_q <= in_prio;
				ev_q <= in_wait_event;
				woken_q <= '0;
				rej_q <= 1'b0;
				need_ins_q <= 1'b0;
				need_pop_q <= 1'b0;
			end
			if (cmd.decode) begin
				case (opcode_t'(op_q))
					OP_READY: begin
						if (!pid_ok || est_q[pid_ix] == ST_READY) rej_q <= 1'b1;
						else begin
							est_q[pid_ix] <= ST_READY;
							epr_q[pid_ix] <= pr_q;
							eev_q[pid_ix] <= '0;
							need_ins_q <= !is_cur &&
								({{(32-LW){1'b0}}, len_q} < NUM_PROCS);
							ins_id_q <= pid_ix;
							ins_pr_q <= pr_q;
						end
					end
					OP_SCHED: begin
						need_ins_q <= curv_q && est_q[cur_q] == ST_READY &&
							({{(32-LW){1'b0}}, len_q} < NUM_PROCS);
						ins_id_q <= cur_q;
						ins_pr_q <= epr_q[cur_q];
						need_pop_q <= 1'b1;
					end
					OP_SLEEP: begin
						if (!curv_q) rej_q <= 1'b1;
						else begin
							eev_q[cur_q] <= ev_q;
							est_q[cur_q] <= ST_SLEEP;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_start) scan_q <= IW'(1);
			else if (cmd.scan_step) scan_q <= scan_q + IW'(1);
			if (st.is_wake && scan_hit && (cmd.ins_start || cmd.scan_step)) begin
				est_q[scan_q] <= ST_READY;
				eev_q[scan_q] <= '0;
				woken_q <= woken_q + 4'd1;
			end
			// removal starts at the head
			if (cmd.pop) ptr_q <= '0;
			if (cmd.ins_start) begin
				ptr_q <= len_q;
				// running sleeper or full queue: mark ready but do not queue
				ins_found_q <= st.is_wake && ((curv_q && cur_q == scan_q) ||
					({{(32-LW){1'b0}}, len_q} >= NUM_PROCS));
				if (st.is_wake) begin
					ins_id_q <= scan_q;
					ins_pr_q <= epr_q[scan_q];
				end
			end else if (cmd.ins_step) begin
				if (st.ins_done) begin
					if (!ins_found_q) begin
						ord_q[IW'(ptr_q)] <= ins_id_q;
						len_q <= len_q + LW'(1);
					end
					ptr_q <= '0;
				end else begin
					ord_q[IW'(ptr_q)] <= ord_m1;
					ptr_q <= ptr_q - LW'(1);
				end
			end
			if (cmd.pop_step) begin
				if (len_q == '0) begin
					curv_q <= 1'b0;
					cur_q <= '0;
				end else begin
					if (ptr_q == '0) cur_q <= ord_q[0];
					if (!st.pop_done) ord_q[IW'(ptr_q)] <= ord_q[IW'(ptr_q + LW'(1))];
					if (st.pop_done) begin
						len_q <= len_q - LW'(1);
						curv_q <= 1'b1;
					end
				end
				ptr_q <= ptr_q + LW'(1);
			end
		end
	end

	assign run_id = curv_q ? 4'({{(32-IW){1'b0}}, cur_q}) : 4'd0;
	assign run_valid = curv_q;
	assign ready_count = 5'({{(32-LW){1'b0}}, len_q});
	assign woken_count = woken_q;
	assign status = rej_q;
endmodule
`default_nettype wire

FILE: rtl/prq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module prq_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [4:0] ready_count,
	input wire logic       run_valid,
	input wire logic [3:0] run_id
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ready_count))
		else $error("result dropped");
	a_idle_run: assert property (@(posedge clk) disable iff (!arst_n)
		!run_valid |-> run_id == 4'd0) else $error("stale run id");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		ready_count <= 5'd16) else $error("queue overflow");
endmodule

bind priority_ready_queue_scheduler prq_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.ready_count(rsp.ready_count), .run_valid(rsp.run_valid), .run_id(rsp.run_id)
);
`default_nettype wire

FILE: tb/sv/tb_priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
module tb_priority_ready_queue_scheduler;
	import prq_pkg::*;

	localparam int NPROC = 16;

	typedef struct packed {
		logic [3:0] run_id;
		logic       run_valid;
		logic [4:0] ready_count;
		logic [3:0] woken_count;
		logic       status;
	} sched_res_t;

	// scoreboard: shadow scheduler state plus the queue of pending results
	class sched_scoreboard;
		pstate_t     st[NPROC];
		logic [7:0]  pr[NPROC];
		logic [15:0] ev[NPROC];
		logic [3:0]  rq[$];
		logic [3:0]  run;
		bit          running;
		sched_res_t  pending[$];
		int          errors;

		function new();
			foreach (st[i]) begin
				st[i] = ST_FREE;
				pr[i] = '0;
				ev[i] = '0;
			end
			run = '0;
			running = 1;
			errors = 0;
		endfunction

		// insert behind every entry of equal or higher priority
		function void enqueue(logic [3:0] id);
			int pos;
			pos = 0;
			while (pos < rq.size() && pr[rq[pos]] >= pr[id])
				pos++;
			rq.insert(pos, id);
		endfunction

		function void note_request(opcode_t op, logic [3:0] pid, logic [7:0] p,
				logic [15:0] e);
			sched_res_t r;
			r = '0;
			case (op)
				OP_READY: begin
					if (st[pid] == ST_READY) begin
						r.status = 1;
					end else begin
						st[pid] = ST_READY;
						pr[pid] = p;
						ev[pid] = '0;
						if (!(running && run == pid))
							enqueue(pid);
					end
				end
				OP_SCHED: begin
					if (running && st[run] == ST_READY)
						enqueue(run);
					if (rq.size() > 0) begin
						run = rq.pop_front();
						running = 1;
					end else begin
						running = 0;
						run = '0;
					end
				end
				OP_SLEEP: begin
					if (!running) begin
						r.status = 1;
					end else begin
						ev[run] = e;
						st[run] = ST_SLEEP;
					end
				end
				default: begin
					for (int i = 1; i < NPROC; i++) begin
						if (st[i] == ST_SLEEP && ev[i] == e) begin
							ev[i] = '0;
							st[i] = ST_READY;
							r.woken_count++;
							if (!(running && run == i))
								enqueue(i[3:0]);
						end
					end
				end
			endcase
			r.run_id = running ? run : 4'd0;
			r.run_valid = running;
			r.ready_count = 5'(rq.size());
			pending.push_back(r);
		endfunction

		function void check_result(sched_res_t got);
			sched_res_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				$display("%0t: mismatch expected %p actual %p", $time, exp, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #4 clk = ~clk;

	prq_in_if req();
	prq_out_if rsp();

	priority_ready_queue_scheduler #(.NUM_PROCS(NPROC)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	sched_scoreboard sb = new();
	bit long_hold = 0;
	bit long_done = 0;
	bit stim_done = 0;
	logic [15:0] ev_pool[4] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000};

	initial begin
		req.valid = 0;
		req.opcode = OP_READY;
		req.proc_id = '0;
		req.prio = '0;
		req.wait_event = '0;
		rsp.ready = 0;
	end

	// one transaction: hold until accepted at a rising edge, change at falling edge
	task automatic send_req(opcode_t op, logic [3:0] pid, logic [7:0] p, logic [15:0] e);
		req.valid <= 1;
		req.opcode <= op;
		req.proc_id <= pid;
		req.prio <= p;
		req.wait_event <= e;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(op, pid, p, e);
		@(negedge clk);
	endtask

	task automatic idle_for(int n);
		req.valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_wait();
		req.valid <= 0;
		while (sb.pending.size() > 0)
			@(negedge clk);
	endtask

	// biased random request: any opcode, mostly pooled events and small priorities
	task automatic send_random();
		opcode_t op;
		logic [15:0] e;
		op = opcode_t'($urandom_range(0, 3));
		e = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ev_pool[$urandom_range(0, 3)];
		send_req(op, 4'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) :
			8'($urandom_range(0, 3)), e);
	endtask

	// result side: random stall pattern plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp.ready <= 0;
				repeat (200) @(negedge clk);
				long_done = 1;
				long_hold = 0;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_result({rsp.run_id, rsp.run_valid, rsp.ready_count,
				rsp.woken_count, rsp.status});
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, rejects, fifo ordering, wakeup while the running entry sleeps
		send_req(OP_SLEEP, 4'd0, 8'd0, 16'hffff);
		send_req(OP_WAKE, 4'd0, 8'd0, 16'hffff);
		send_req(OP_READY, 4'd0, 8'hff, 16'd0);
		send_req(OP_READY, 4'd0, 8'h00, 16'd0);
		send_req(OP_READY, 4'd15, 8'hff, 16'hffff);
		send_req(OP_READY, 4'd3, 8'h80, 16'd0);
		send_req(OP_READY, 4'd5, 8'h80, 16'd0);
		send_req(OP_READY, 4'd7, 8'h00, 16'd0);
		send_req(OP_SCHED, 4'd0, 8'd0, 16'd0);
		send_req(OP_SLEEP, 4'd0, 8'd0, 16'h1234);
		send_req(OP_SCHED, 4'd0, 8'd0, 16'd0);
		send_req(OP_SLEEP, 4'd0, 8'd0, 16'h1234);
		send_req(OP_WAKE, 4'd0, 8'd0, 16'h1234);
		send_req(OP_SCHED, 4'd0, 8'd0, 16'd0);
		repeat (6) send_req(OP_SCHED, 4'd0, 8'd0, 16'd0);
		send_req(OP_SLEEP, 4'd0, 8'd0, 16'h0000);
		send_req(OP_READY, 4'hf, 8'h7f, 16'd0);
		send_req(OP_WAKE, 4'd0, 8'd0, 16'h0000);

		// sender pauses until every result is back
		drain_wait();

		// receiver holds off while requests keep coming
		long_hold = 1;
		repeat (20) send_random();
		while (!long_done) @(negedge clk);

		for (int n = 0; n < 600; ) begin
			int burst;
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst; b++, n++)
				send_random();
			if ($urandom_range(0, 1))
				idle_for($urandom_range(1, 12));
		end
		drain_wait();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_priority_ready_queue_scheduler OK");
		else
			$display("tb_priority_ready_queue_scheduler NOT OK");
		$finish;
	end

	// guard against a hang
	initial begin
		#4000000;
		$display("tb_priority_ready_queue_scheduler NOT OK");
		$finish;
	end
endmodule
